// ===== sv/idm_car_following_speed_update_defines.svh =====
// Assertion macros shared by the car-following speed update design.
`ifndef IDM_CAR_FOLLOWING_SPEED_UPDATE_DEFINES_SVH
`define IDM_CAR_FOLLOWING_SPEED_UPDATE_DEFINES_SVH
`ifndef SYNTHESIS
`define IDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IDM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IDM_ASSERT(lbl, prop, msg)
`define IDM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== sv/idm_pkg.sv =====
// Types, widths and constants of the car-following speed update design.
package idm_pkg;

  localparam int GapW     = 24;
  localparam int SpdW     = 16;
  localparam int AccW     = 12;
  localparam int TimeW    = 12;
  localparam int ExpW     = 4;
  localparam int DtW      = 16;
  localparam int FracW    = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  localparam int SqrtInW  = 2 * AccW;
  localparam int RootW    = SqrtInW / 2;
  localparam int DenW     = RootW + 1;
  localparam int NdW      = 2 * SpdW;
  localparam int VtW      = SpdW + TimeW - 8;
  localparam int RatioW   = 32;
  localparam int RatioNumW = SpdW + FracW;
  localparam int GapNumW  = GapW + FracW;
  localparam int PowSteps = (1 << ExpW) - 1;
  localparam int AdW      = AccW + DtW;
  localparam int FacW     = 34;

  localparam logic [CfgIdxW-1:0] CfgMinGap     = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgTimeHeadway = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgComfortDecel = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgAccelExp   = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] CfgTimeStep   = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] CfgModelMode  = CfgIdxW'(5);

  localparam logic [RatioW-1:0] RatioCap = 32'h8000_0000;
  localparam logic [RatioW-1:0] QOne     = 32'h0001_0000;
  localparam logic [63:0]       QHalf    = 64'h0000_0000_0000_8000;
  localparam logic [GapW-1:0]   GapMax   = 24'hFF_FFFF;

  typedef struct packed {
    logic [GapW-1:0]  min_gap;
    logic [TimeW-1:0] time_headway;
    logic [AccW-1:0]  comfort_decel;
    logic [ExpW-1:0]  accel_exponent;
    logic [DtW-1:0]   time_step;
    logic             model_mode;
  } idm_cfg_t;

  localparam idm_cfg_t CfgReset = '{
    min_gap:        24'd512,
    time_headway:   12'd384,
    comfort_decel:  12'd427,
    accel_exponent: 4'd4,
    time_step:      16'd6554,
    model_mode:     1'b0
  };

  typedef struct packed {
    logic            leader_present;
    logic [GapW-1:0] leader_gap;
    logic [SpdW-1:0] leader_speed;
    logic [SpdW-1:0] own_speed;
    logic [SpdW-1:0] top_speed;
    logic [AccW-1:0] top_accel;
  } idm_in_t;

  typedef struct packed {
    logic signed [SpdW-1:0] new_speed;
    logic [GapW-1:0]        desired_gap;
    logic                   saturated;
  } idm_out_t;

  typedef struct packed {
    logic            lp;
    logic [GapW-1:0] gap;
    logic [SpdW-1:0] v;
    logic [SpdW-1:0] vm;
    logic [AccW-1:0] a;
    logic [VtW-1:0]  vt;
  } idm_quot_tag_t;

  typedef struct packed {
    idm_quot_tag_t  base;
    logic           neg;
    logic [NdW-1:0] nd;
  } idm_root_tag_t;

  typedef struct packed {
    logic            lp;
    logic [GapW-1:0] gap;
    logic [SpdW-1:0] v;
    logic [SpdW-1:0] vm;
    logic [AccW-1:0] a;
    logic [GapW-1:0] s;
    logic            gsat;
  } idm_gap_tag_t;

  typedef struct packed {
    idm_gap_tag_t      gt;
    logic [RatioW-1:0] p;
  } idm_q_tag_t;

  typedef struct packed {
    logic            lp;
    logic [SpdW-1:0] v;
    logic [SpdW-1:0] vm;
    logic [GapW-1:0] desired_gap;
    logic            sat;
  } idm_fin_tag_t;

endpackage

// ===== sv/idm_isqrt.sv =====
// Pipelined floor square root, one root bit per stage, with a tag riding along.
module idm_isqrt #(
  parameter int TagW = $bits(idm_pkg::idm_root_tag_t)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [idm_pkg::SqrtInW-1:0] in_x,
  input  logic [TagW-1:0]             in_tag,
  output logic                        out_vld,
  output logic [idm_pkg::RootW-1:0]   out_root,
  output logic [TagW-1:0]             out_tag
);

  localparam int Steps = idm_pkg::RootW;
  localparam int XW    = idm_pkg::SqrtInW;
  localparam int RemW  = Steps + 2;

  logic             vld_r  [Steps];
  logic [RemW-1:0]  rem_r  [Steps];
  logic [Steps-1:0] root_r [Steps];
  logic [XW-1:0]    x_r    [Steps];
  logic [TagW-1:0]  tag_r  [Steps];

  for (genvar i = 0; i < Steps; i++) begin : g_st
    logic             vld_in;
    logic [RemW-1:0]  rem_in;
    logic [Steps-1:0] root_in;
    logic [XW-1:0]    x_in;
    logic [TagW-1:0]  tag_in;
    logic [RemW-1:0]  trial;
    logic [RemW-1:0]  test;
    logic             fits;

    if (i == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = in_x;
      assign tag_in  = in_tag;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign x_in    = x_r[i-1];
      assign tag_in  = tag_r[i-1];
    end

    assign trial = {rem_in[RemW-3:0], x_in[XW-1 -: 2]};
    assign test  = {root_in, 2'b01};
    assign fits  = trial >= test;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i]  <= fits ? (trial - test) : trial;
      root_r[i] <= {root_in[Steps-2:0], fits};
      x_r[i]    <= {x_in[XW-3:0], 2'b00};
      tag_r[i]  <= tag_in;
    end
  end

  assign out_vld  = vld_r[Steps-1];
  assign out_root = root_r[Steps-1];
  assign out_tag  = tag_r[Steps-1];

endmodule

// ===== sv/idm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a tag riding along.
module idm_div #(
  parameter int NumW = idm_pkg::RatioNumW,
  parameter int DenW = idm_pkg::SpdW,
  parameter int TagW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  logic [NumW-1:0] in_num,
  input  logic [DenW-1:0] in_den,
  input  logic [TagW-1:0] in_tag,
  output logic            out_vld,
  output logic [NumW-1:0] out_quo,
  output logic [TagW-1:0] out_tag
);

  logic            vld_r [NumW];
  logic [DenW-1:0] rem_r [NumW];
  logic [NumW-1:0] quo_r [NumW];
  logic [NumW-1:0] num_r [NumW];
  logic [DenW-1:0] den_r [NumW];
  logic [TagW-1:0] tag_r [NumW];

  for (genvar i = 0; i < NumW; i++) begin : g_st
    logic            vld_in;
    logic [DenW-1:0] rem_in;
    logic [NumW-1:0] quo_in;
    logic [NumW-1:0] num_in;
    logic [DenW-1:0] den_in;
    logic [TagW-1:0] tag_in;
    logic [DenW:0]   trial;
    logic [DenW:0]   diff;
    logic            fits;

    if (i == 0) begin : g_first
      assign vld_in = in_vld;
      assign rem_in = '0;
      assign quo_in = '0;
      assign num_in = in_num;
      assign den_in = in_den;
      assign tag_in = in_tag;
    end else begin : g_next
      assign vld_in = vld_r[i-1];
      assign rem_in = rem_r[i-1];
      assign quo_in = quo_r[i-1];
      assign num_in = num_r[i-1];
      assign den_in = den_r[i-1];
      assign tag_in = tag_r[i-1];
    end

    assign trial = {rem_in, num_in[NumW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign fits  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i] <= fits ? diff[DenW-1:0] : trial[DenW-1:0];
      quo_r[i] <= {quo_in[NumW-2:0], fits};
      num_r[i] <= {num_in[NumW-2:0], 1'b0};
      den_r[i] <= den_in;
      tag_r[i] <= tag_in;
    end
  end

  assign out_vld = vld_r[NumW-1];
  assign out_quo = quo_r[NumW-1];
  assign out_tag = tag_r[NumW-1];

endmodule

// ===== sv/idm_pow.sv =====
// Pipelined integer power of the speed ratio, one rounded multiply per stage.
module idm_pow #(
  parameter int TagW = $bits(idm_pkg::idm_gap_tag_t)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [idm_pkg::ExpW-1:0]   in_exp,
  input  logic [idm_pkg::RatioW-1:0] in_r,
  input  logic [TagW-1:0]            in_tag,
  output logic                       out_vld,
  output logic [idm_pkg::RatioW-1:0] out_p,
  output logic [TagW-1:0]            out_tag
);

  localparam int Steps = idm_pkg::PowSteps;
  localparam int RW    = idm_pkg::RatioW;

  logic            vld_r [Steps];
  logic [RW-1:0]   p_r   [Steps];
  logic [RW-1:0]   r_r   [Steps];
  logic [TagW-1:0] tag_r [Steps];

  for (genvar i = 0; i < Steps; i++) begin : g_st
    logic            vld_in;
    logic [RW-1:0]   p_in;
    logic [RW-1:0]   r_in;
    logic [TagW-1:0] tag_in;
    logic [63:0]     prod;
    logic [47:0]     rnd;
    logic [RW-1:0]   capped;
    logic            active;

    if (i == 0) begin : g_first
      assign vld_in = in_vld;
      assign p_in   = idm_pkg::QOne;
      assign r_in   = in_r;
      assign tag_in = in_tag;
    end else begin : g_next
      assign vld_in = vld_r[i-1];
      assign p_in   = p_r[i-1];
      assign r_in   = r_r[i-1];
      assign tag_in = tag_r[i-1];
    end

    assign prod   = 64'(p_in) * 64'(r_in);
    assign rnd    = 48'((prod + idm_pkg::QHalf) >> 16);
    assign capped = (rnd > 48'(idm_pkg::RatioCap)) ? idm_pkg::RatioCap : rnd[RW-1:0];
    assign active = idm_pkg::ExpW'(i) < in_exp;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      p_r[i]   <= active ? capped : p_in;
      r_r[i]   <= r_in;
      tag_r[i] <= tag_in;
    end
  end

  assign out_vld = vld_r[Steps-1];
  assign out_p   = p_r[Steps-1];
  assign out_tag = tag_r[Steps-1];

endmodule

// ===== sv/idm_car_following_speed_update.sv =====
// Top level of the car-following speed update pipeline.
// One vehicle word is taken every clock cycle and its result appears on out_valid for one
// cycle; busy is always low. Words pass the 12-stage square root, the 32-stage desired-gap
// divider, the 15-stage power pipeline and the 40-stage gap-ratio divider, plus arithmetic
// registers. Results cannot be held off, so no word is ever stalled. Configuration must be
// written through the plain write port only while idle; the block itself does not enforce this.
`include "idm_car_following_speed_update_defines.svh"

module idm_car_following_speed_update (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  idm_pkg::idm_in_t             in_data,
  output logic                         out_valid,
  output idm_pkg::idm_out_t            out_data,
  input  logic                         cfg_we,
  input  logic [idm_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [idm_pkg::CfgDataW-1:0] cfg_wdata
);

  localparam int Latency = 2 + idm_pkg::RootW + idm_pkg::RatioNumW + 1 + idm_pkg::PowSteps
                           + idm_pkg::GapNumW + 6;

  idm_pkg::idm_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= idm_pkg::CfgReset;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        idm_pkg::CfgMinGap:       cfg_r.min_gap        <= cfg_wdata[idm_pkg::GapW-1:0];
        idm_pkg::CfgTimeHeadway:  cfg_r.time_headway   <= cfg_wdata[idm_pkg::TimeW-1:0];
        idm_pkg::CfgComfortDecel: cfg_r.comfort_decel  <= cfg_wdata[idm_pkg::AccW-1:0];
        idm_pkg::CfgAccelExp:     cfg_r.accel_exponent <= cfg_wdata[idm_pkg::ExpW-1:0];
        idm_pkg::CfgTimeStep:     cfg_r.time_step      <= cfg_wdata[idm_pkg::DtW-1:0];
        idm_pkg::CfgModelMode:    cfg_r.model_mode     <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign busy = 1'b0;

  // Input register.
  logic             a_vld_r;
  idm_pkg::idm_in_t a_r;

  // Products and speed difference.
  logic                         b_vld_r;
  logic [idm_pkg::SqrtInW-1:0]  b_ab_r;
  idm_pkg::idm_root_tag_t       b_tag_r;
  idm_pkg::idm_root_tag_t       b_tag_nxt;
  logic [idm_pkg::SpdW-1:0]     b_mag;
  logic [27:0]                  b_vt_full;

  always_comb begin
    b_tag_nxt.base.lp  = a_r.leader_present;
    b_tag_nxt.base.gap = a_r.leader_gap;
    b_tag_nxt.base.v   = a_r.own_speed;
    b_tag_nxt.base.vm  = a_r.top_speed;
    b_tag_nxt.base.a   = a_r.top_accel;
    b_vt_full          = 28'(a_r.own_speed) * 28'(cfg_r.time_headway);
    b_tag_nxt.base.vt  = b_vt_full[27:8];
    b_tag_nxt.neg      = a_r.own_speed < a_r.leader_speed;
    b_mag = b_tag_nxt.neg ? (a_r.leader_speed - a_r.own_speed)
                          : (a_r.own_speed - a_r.leader_speed);
    b_tag_nxt.nd = 32'(a_r.own_speed) * 32'(b_mag);
  end

  always_ff @(posedge clk) begin
    a_r     <= in_data;
    b_ab_r  <= 24'(a_r.top_accel) * 24'(cfg_r.comfort_decel);
    b_tag_r <= b_tag_nxt;
  end

  // Square root of a times b.
  logic                              rt_vld;
  logic [idm_pkg::RootW-1:0]         rt_root;
  logic [$bits(idm_pkg::idm_root_tag_t)-1:0] rt_tag_vec;
  idm_pkg::idm_root_tag_t            rt_tag;
  logic [idm_pkg::DenW-1:0]          rt_den;
  logic [idm_pkg::SpdW-1:0]          rt_vd;

  idm_isqrt #(
    .TagW ($bits(idm_pkg::idm_root_tag_t))
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (b_vld_r),
    .in_x     (b_ab_r),
    .in_tag   (b_tag_r),
    .out_vld  (rt_vld),
    .out_root (rt_root),
    .out_tag  (rt_tag_vec)
  );

  assign rt_tag = idm_pkg::idm_root_tag_t'(rt_tag_vec);
  assign rt_den = (rt_root == '0) ? idm_pkg::DenW'(1) : {rt_root, 1'b0};
  assign rt_vd  = (rt_tag.base.vm == '0) ? idm_pkg::SpdW'(1) : rt_tag.base.vm;

  // Dynamic gap term and speed ratio, divided side by side.
  logic                                      dm_vld;
  logic [idm_pkg::NdW-1:0]                   dm_quo;
  logic [$bits(idm_pkg::idm_quot_tag_t)-1:0] dm_tag_vec;
  idm_pkg::idm_quot_tag_t                    dm_tag;
  logic [idm_pkg::RatioNumW-1:0]             dr_quo;
  logic                                      dr_neg;

  idm_div #(
    .NumW (idm_pkg::NdW),
    .DenW (idm_pkg::DenW),
    .TagW ($bits(idm_pkg::idm_quot_tag_t))
  ) u_div_gap (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (rt_vld),
    .in_num  (rt_tag.nd),
    .in_den  (rt_den),
    .in_tag  (rt_tag.base),
    .out_vld (dm_vld),
    .out_quo (dm_quo),
    .out_tag (dm_tag_vec)
  );

  idm_div #(
    .NumW (idm_pkg::RatioNumW),
    .DenW (idm_pkg::SpdW),
    .TagW (1)
  ) u_div_ratio (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (rt_vld),
    .in_num  ({rt_tag.base.v, idm_pkg::FracW'(0)}),
    .in_den  (rt_vd),
    .in_tag  (rt_tag.neg),
    .out_vld (),
    .out_quo (dr_quo),
    .out_tag (dr_neg)
  );

  assign dm_tag = idm_pkg::idm_quot_tag_t'(dm_tag_vec);

  // Desired gap and ratio cap.
  logic                        s_vld_r;
  idm_pkg::idm_gap_tag_t       s_tag_r;
  idm_pkg::idm_gap_tag_t       s_tag_nxt;
  logic [idm_pkg::RatioW-1:0]  s_ratio_r;
  logic [idm_pkg::RatioW-1:0]  s_ratio_nxt;
  logic signed [33:0]          s_sum;
  logic [33:0]                 s_full;

  always_comb begin
    s_sum = dr_neg ? ($signed(34'(dm_tag.vt)) - $signed(34'(dm_quo)))
                   : ($signed(34'(dm_tag.vt)) + $signed(34'(dm_quo)));
    s_full = 34'(cfg_r.min_gap) + (s_sum[33] ? 34'(0) : 34'(s_sum[32:0]));
    s_tag_nxt.lp   = dm_tag.lp;
    s_tag_nxt.gap  = dm_tag.gap;
    s_tag_nxt.v    = dm_tag.v;
    s_tag_nxt.vm   = dm_tag.vm;
    s_tag_nxt.a    = dm_tag.a;
    s_tag_nxt.gsat = s_full > 34'(idm_pkg::GapMax);
    s_tag_nxt.s    = s_tag_nxt.gsat ? idm_pkg::GapMax : s_full[idm_pkg::GapW-1:0];
    s_ratio_nxt    = (dr_quo > idm_pkg::RatioCap) ? idm_pkg::RatioCap : dr_quo;
  end

  always_ff @(posedge clk) begin
    s_tag_r   <= s_tag_nxt;
    s_ratio_r <= s_ratio_nxt;
  end

  // Power of the speed ratio.
  logic                                     pw_vld;
  logic [idm_pkg::RatioW-1:0]               pw_p;
  logic [$bits(idm_pkg::idm_gap_tag_t)-1:0] pw_tag_vec;
  idm_pkg::idm_q_tag_t                      pw_qtag;

  idm_pow #(
    .TagW ($bits(idm_pkg::idm_gap_tag_t))
  ) u_pow (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s_vld_r),
    .in_exp  (cfg_r.accel_exponent),
    .in_r    (s_ratio_r),
    .in_tag  (s_tag_r),
    .out_vld (pw_vld),
    .out_p   (pw_p),
    .out_tag (pw_tag_vec)
  );

  assign pw_qtag.gt = idm_pkg::idm_gap_tag_t'(pw_tag_vec);
  assign pw_qtag.p  = pw_p;

  // Gap ratio.
  logic                                   dq_vld;
  logic [idm_pkg::GapNumW-1:0]            dq_quo;
  logic [$bits(idm_pkg::idm_q_tag_t)-1:0] dq_tag_vec;
  idm_pkg::idm_q_tag_t                    dq_tag;

  idm_div #(
    .NumW (idm_pkg::GapNumW),
    .DenW (idm_pkg::GapW),
    .TagW ($bits(idm_pkg::idm_q_tag_t))
  ) u_div_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (pw_vld),
    .in_num  ({pw_qtag.gt.s, idm_pkg::FracW'(0)}),
    .in_den  (pw_qtag.gt.gap),
    .in_tag  (pw_qtag),
    .out_vld (dq_vld),
    .out_quo (dq_quo),
    .out_tag (dq_tag_vec)
  );

  assign dq_tag = idm_pkg::idm_q_tag_t'(dq_tag_vec);

  // Ratio cap, zero gap.
  logic                        q1_vld_r;
  logic [idm_pkg::RatioW-1:0]  q1_q_r;
  logic                        q1_gz_r;
  idm_pkg::idm_q_tag_t         q1_tag_r;
  logic                        q1_gz;

  assign q1_gz = dq_tag.gt.gap == '0;

  always_ff @(posedge clk) begin
    q1_gz_r  <= q1_gz;
    q1_tag_r <= dq_tag;
    if (q1_gz || dq_quo > idm_pkg::GapNumW'(idm_pkg::RatioCap)) begin
      q1_q_r <= idm_pkg::RatioCap;
    end else begin
      q1_q_r <= dq_quo[idm_pkg::RatioW-1:0];
    end
  end

  // Square of the gap ratio, a times time step.
  logic                       q2_vld_r;
  logic [63:0]                q2_qq_r;
  logic [idm_pkg::AdW-1:0]    q2_ad_r;
  logic                       q2_gz_r;
  idm_pkg::idm_q_tag_t        q2_tag_r;

  always_ff @(posedge clk) begin
    q2_qq_r  <= 64'(q1_q_r) * 64'(q1_q_r);
    q2_ad_r  <= idm_pkg::AdW'(q1_tag_r.gt.a) * idm_pkg::AdW'(cfg_r.time_step);
    q2_gz_r  <= q1_gz_r;
    q2_tag_r <= q1_tag_r;
  end

  // Acceleration factor.
  logic                          q3_vld_r;
  logic signed [idm_pkg::FacW-1:0] q3_fac_r;
  logic [idm_pkg::AdW-1:0]       q3_ad_r;
  idm_pkg::idm_fin_tag_t         q3_tag_r;
  logic [47:0]                   q3_q2;
  logic signed [49:0]            q3_one;
  logic signed [49:0]            q3_p;
  logic signed [49:0]            q3_qs;
  logic signed [49:0]            q3_ft;
  logic signed [49:0]            q3_it;
  logic signed [49:0]            q3_raw;
  logic signed [49:0]            q3_cl;
  idm_pkg::idm_fin_tag_t         q3_tag_nxt;

  always_comb begin
    q3_q2  = 48'((q2_qq_r + idm_pkg::QHalf) >> 16);
    q3_one = $signed(50'(idm_pkg::QOne));
    q3_p   = $signed(50'(q2_tag_r.p));
    q3_qs  = $signed(50'(q3_q2));
    q3_ft  = q3_one - q3_p;
    q3_it  = q3_one - q3_qs;
    if (cfg_r.model_mode) begin
      q3_raw = q3_ft - q3_qs;
    end else begin
      q3_raw = (q3_ft < q3_it) ? q3_ft : q3_it;
    end
    if (q3_raw < -50'sd4294967296) begin
      q3_cl = -50'sd4294967296;
    end else if (q3_raw > 50'sd4294967296) begin
      q3_cl = 50'sd4294967296;
    end else begin
      q3_cl = q3_raw;
    end
    if (!q2_tag_r.gt.lp) begin
      q3_cl = q3_one;
    end
    q3_tag_nxt.lp  = q2_tag_r.gt.lp;
    q3_tag_nxt.v   = q2_tag_r.gt.v;
    q3_tag_nxt.vm  = q2_tag_r.gt.vm;
    q3_tag_nxt.desired_gap = (q2_tag_r.gt.lp && cfg_r.model_mode) ? q2_tag_r.gt.s : '0;
    q3_tag_nxt.sat = q2_tag_r.gt.lp && (q2_tag_r.gt.gsat || q2_gz_r);
  end

  always_ff @(posedge clk) begin
    q3_fac_r <= idm_pkg::FacW'(q3_cl);
    q3_ad_r  <= q2_ad_r;
    q3_tag_r <= q3_tag_nxt;
  end

  // Partial products of a times factor times time step.
  logic                   q4_vld_r;
  logic signed [45:0]     q4_hi_r;
  logic [44:0]            q4_lo_r;
  idm_pkg::idm_fin_tag_t  q4_tag_r;

  always_ff @(posedge clk) begin
    q4_hi_r  <= $signed({1'b0, q3_ad_r}) * $signed(q3_fac_r[33:17]);
    q4_lo_r  <= 45'(q3_ad_r) * 45'(q3_fac_r[16:0]);
    q4_tag_r <= q3_tag_r;
  end

  // Speed change, floor of the product over two to the 32.
  logic                   q5_vld_r;
  logic signed [30:0]     q5_dv_r;
  idm_pkg::idm_fin_tag_t  q5_tag_r;
  logic signed [62:0]     q5_prod;

  assign q5_prod = (63'(q4_hi_r) <<< 17) + $signed(63'(q4_lo_r));

  always_ff @(posedge clk) begin
    q5_dv_r  <= $signed(q5_prod[62:32]);
    q5_tag_r <= q4_tag_r;
  end

  // New speed, limits and saturation.
  logic               out_valid_r;
  idm_pkg::idm_out_t  out_data_r;
  idm_pkg::idm_out_t  out_data_nxt;
  logic signed [31:0] o_nv0;
  logic signed [31:0] o_vm;
  logic signed [31:0] o_nv1;

  always_comb begin
    o_nv0 = $signed({16'b0, q5_tag_r.v}) + 32'(q5_dv_r);
    o_vm  = $signed({16'b0, q5_tag_r.vm});
    o_nv1 = (o_nv0 > o_vm) ? o_vm : o_nv0;
    if (q5_tag_r.lp && !cfg_r.model_mode && o_nv1 < 32'sd0) begin
      o_nv1 = 32'sd0;
    end
    out_data_nxt.desired_gap = q5_tag_r.desired_gap;
    out_data_nxt.saturated   = q5_tag_r.sat;
    if (o_nv1 > 32'sd32767) begin
      out_data_nxt.new_speed = 16'sh7FFF;
      out_data_nxt.saturated = 1'b1;
    end else if (o_nv1 < -32'sd32768) begin
      out_data_nxt.new_speed = 16'sh8000;
      out_data_nxt.saturated = 1'b1;
    end else begin
      out_data_nxt.new_speed = o_nv1[15:0];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      s_vld_r     <= 1'b0;
      q1_vld_r    <= 1'b0;
      q2_vld_r    <= 1'b0;
      q3_vld_r    <= 1'b0;
      q4_vld_r    <= 1'b0;
      q5_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_vld_r     <= start && !busy;
      b_vld_r     <= a_vld_r;
      s_vld_r     <= dm_vld;
      q1_vld_r    <= dq_vld;
      q2_vld_r    <= q1_vld_r;
      q3_vld_r    <= q2_vld_r;
      q4_vld_r    <= q3_vld_r;
      q5_vld_r    <= q4_vld_r;
      out_valid_r <= q5_vld_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `IDM_ASSERT(a_word_out, start && !busy |-> ##Latency out_valid, "accepted word lost")
  `IDM_ASSERT(a_no_extra, out_valid |-> $past(start && !busy, Latency), "result without word")
  `IDM_ASSERT(a_mod_gap, out_valid && !cfg_r.model_mode |-> out_data.desired_gap == '0, "gap shown")
  `IDM_ASSERT_ALWAYS(a_rst_clr, !rst_n |=> !out_valid, "strobe after reset")

endmodule

// ===== test/tb_idm_car_following_speed_update.sv =====
// Testbench for the car-following speed update with an in-bench fixed-point predictor.
`timescale 1ns / 1ps

module tb_idm_car_following_speed_update;

  localparam int Latency = 108;
  localparam longint CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  idm_pkg::idm_in_t in_data = '0;
  logic out_valid;
  idm_pkg::idm_out_t out_data;
  logic cfg_we = 1'b0;
  logic [idm_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [idm_pkg::CfgDataW-1:0] cfg_wdata = '0;

  idm_pkg::idm_cfg_t cur_cfg;
  idm_pkg::idm_out_t speed_queue[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int sat_seen = 0;
  longint cycles = 0;

  idm_car_following_speed_update dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL idm_car_following_speed_update");
      $finish;
    end
  end

  function automatic logic [63:0] floor_root(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 30;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic idm_pkg::idm_out_t predict_speed(idm_pkg::idm_in_t w);
    logic [63:0] den, m, r, p, q, q2, s, vd, g, v, vl, vm, a;
    longint sum, factor, nv, prod, fterm, iterm;
    logic sat;
    logic [63:0] gap_out;
    idm_pkg::idm_out_t o;
    g = w.leader_gap; vl = w.leader_speed; v = w.own_speed;
    vm = w.top_speed; a = w.top_accel;
    sat = 1'b0;
    gap_out = 0;
    factor = 65536;
    if (w.leader_present) begin
      den = 2 * floor_root(a * cur_cfg.comfort_decel);
      if (den == 0) den = 1;
      if (v >= vl) begin
        m = (v * (v - vl)) / den;
        sum = longint'((v * cur_cfg.time_headway) >> 8) + longint'(m);
      end else begin
        m = (v * (vl - v)) / den;
        sum = longint'((v * cur_cfg.time_headway) >> 8) - longint'(m);
      end
      s = 64'(cur_cfg.min_gap) + (sum > 0 ? 64'(sum) : 64'd0);
      if (s > 64'(idm_pkg::GapMax)) begin
        s = 64'(idm_pkg::GapMax);
        sat = 1'b1;
      end
      vd = (vm != 0) ? vm : 64'd1;
      r = (v << 16) / vd;
      if (r > 64'(idm_pkg::RatioCap)) r = 64'(idm_pkg::RatioCap);
      p = 64'd65536;
      for (int i = 0; i < cur_cfg.accel_exponent; i++) begin
        p = (p * r + 64'd32768) >> 16;
        if (p > 64'(idm_pkg::RatioCap)) p = 64'(idm_pkg::RatioCap);
      end
      if (g == 0) begin
        q = 64'(idm_pkg::RatioCap);
        sat = 1'b1;
      end else begin
        q = (s << 16) / g;
        if (q > 64'(idm_pkg::RatioCap)) q = 64'(idm_pkg::RatioCap);
      end
      q2 = (q * q + 64'd32768) >> 16;
      fterm = 65536 - longint'(p);
      iterm = 65536 - longint'(q2);
      if (cur_cfg.model_mode) factor = 65536 - longint'(p) - longint'(q2);
      else factor = (fterm < iterm) ? fterm : iterm;
      if (factor > 64'sd4294967296) factor = 64'sd4294967296;
      if (factor < -64'sd4294967296) factor = -64'sd4294967296;
      gap_out = cur_cfg.model_mode ? s : 64'd0;
    end
    prod = longint'(a) * factor * longint'(cur_cfg.time_step);
    nv = longint'(v) + (prod >>> 32);
    if (nv > longint'(vm)) nv = longint'(vm);
    if (w.leader_present && !cur_cfg.model_mode && nv < 0) nv = 0;
    if (nv > 32767) begin
      nv = 32767;
      sat = 1'b1;
    end
    if (nv < -32768) begin
      nv = -32768;
      sat = 1'b1;
    end
    o.new_speed = nv[15:0];
    o.desired_gap = gap_out[23:0];
    o.saturated = sat;
    return o;
  endfunction

  always @(posedge clk) begin : check_proc
    idm_pkg::idm_out_t exp_w;
    if (rst_n && out_valid) begin
      if (speed_queue.size() == 0) begin
        $error("result word with no expectation");
        errors++;
      end else begin
        exp_w = speed_queue.pop_front();
        words_checked++;
        if (exp_w.saturated) sat_seen++;
        if (out_data.new_speed !== exp_w.new_speed) begin
          $error("new_speed expected %0d actual %0d", exp_w.new_speed, out_data.new_speed);
          errors++;
        end
        if (out_data.desired_gap !== exp_w.desired_gap) begin
          $error("desired_gap expected %0d actual %0d", exp_w.desired_gap,
                 out_data.desired_gap);
          errors++;
        end
        if (out_data.saturated !== exp_w.saturated) begin
          $error("saturated expected %0d actual %0d", exp_w.saturated, out_data.saturated);
          errors++;
        end
      end
    end
  end

  // Sends one word: start stays high across back-to-back words when keep_going is set.
  task automatic send_word(idm_pkg::idm_in_t w, bit keep_going);
    start <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    speed_queue.push_back(predict_speed(w));
    words_sent++;
    @(negedge clk);
    if (!keep_going) start <= 1'b0;
  endtask

  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (speed_queue.size() != 0) @(negedge clk);
    repeat (Latency + 10) @(negedge clk);
  endtask

  task automatic write_reg(logic [idm_pkg::CfgIdxW-1:0] idx,
                           logic [idm_pkg::CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    unique case (idx)
      idm_pkg::CfgMinGap: cur_cfg.min_gap = val;
      idm_pkg::CfgTimeHeadway: cur_cfg.time_headway = val[11:0];
      idm_pkg::CfgComfortDecel: cur_cfg.comfort_decel = val[11:0];
      idm_pkg::CfgAccelExp: cur_cfg.accel_exponent = val[3:0];
      idm_pkg::CfgTimeStep: cur_cfg.time_step = val[15:0];
      idm_pkg::CfgModelMode: cur_cfg.model_mode = val[0];
      default: ;
    endcase
  endtask

  task automatic load_config(idm_pkg::idm_cfg_t c);
    write_reg(idm_pkg::CfgMinGap, c.min_gap);
    write_reg(idm_pkg::CfgTimeHeadway, 24'(c.time_headway));
    write_reg(idm_pkg::CfgComfortDecel, 24'(c.comfort_decel));
    write_reg(idm_pkg::CfgAccelExp, 24'(c.accel_exponent));
    write_reg(idm_pkg::CfgTimeStep, 24'(c.time_step));
    write_reg(idm_pkg::CfgModelMode, 24'(c.model_mode));
  endtask

  function automatic idm_pkg::idm_in_t rand_word();
    idm_pkg::idm_in_t w;
    int k;
    w.leader_present = $urandom_range(0, 7) != 0;
    w.own_speed = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 10000));
    w.leader_speed = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                               : 16'($urandom_range(0, 10000));
    w.top_speed = $urandom_range(0, 3) == 0 ? 16'($urandom_range(1, 65535))
                                            : 16'($urandom_range(2000, 12000));
    w.top_accel = $urandom_range(0, 3) == 0 ? 12'($urandom_range(1, 4095))
                                            : 12'($urandom_range(128, 700));
    k = $urandom_range(0, 9);
    if (k == 0) w.leader_gap = 24'($urandom);
    else if (k == 1) w.leader_gap = 24'($urandom_range(0, 256));
    else w.leader_gap = 24'($urandom_range(256, 40000));
    return w;
  endfunction

  function automatic idm_pkg::idm_cfg_t rand_config();
    idm_pkg::idm_cfg_t c;
    c.min_gap = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 2000));
    c.time_headway = 12'($urandom);
    c.comfort_decel = 12'($urandom_range(1, 4095));
    c.accel_exponent = 4'($urandom_range(1, 8));
    c.time_step = 16'($urandom_range(1, 65535));
    c.model_mode = 1'($urandom);
    return c;
  endfunction

  task automatic test_directed();
    idm_pkg::idm_in_t w;
    idm_pkg::idm_in_t base;
    base = '{leader_present: 1'b1, leader_gap: 24'd5120, leader_speed: 16'd2560,
             own_speed: 16'd3000, top_speed: 16'd8000, top_accel: 12'd300};
    for (int mode = 0; mode < 2; mode++) begin
      write_reg(idm_pkg::CfgModelMode, 24'(mode));
      send_word(base, 1);
      w = base; w.leader_present = 1'b0; send_word(w, 1);
      w = base; w.leader_gap = '0; send_word(w, 1);
      w = base; w.leader_gap = 24'hFFFFFF; send_word(w, 1);
      w = base; w.own_speed = 16'hFFFF; w.top_speed = 16'hFFFF; send_word(w, 1);
      w = base; w.leader_speed = 16'hFFFF; w.own_speed = 16'd0; send_word(w, 1);
      w = base; w.top_speed = 16'd1; w.own_speed = 16'd0; send_word(w, 1);
      w = base; w.top_accel = 12'hFFF; w.leader_gap = 24'd1; send_word(w, 1);
      w = base; w.top_accel = 12'd1; send_word(w, 1);
      w = base; w.leader_present = 1'b0; w.own_speed = 16'hFFFF; w.top_speed = 16'hFFFF;
      w.top_accel = 12'hFFF; send_word(w, 0);
      drain();
    end
  endtask

  task automatic test_config_extremes();
    idm_pkg::idm_cfg_t c;
    c = '{min_gap: 24'hFFFFFF, time_headway: 12'hFFF, comfort_decel: 12'd1,
          accel_exponent: 4'd8, time_step: 16'hFFFF, model_mode: 1'b1};
    load_config(c);
    for (int i = 0; i < 12; i++) send_word(rand_word(), i != 11);
    drain();
    c = '{min_gap: 24'd0, time_headway: 12'd0, comfort_decel: 12'hFFF,
          accel_exponent: 4'd1, time_step: 16'd1, model_mode: 1'b0};
    load_config(c);
    for (int i = 0; i < 12; i++) send_word(rand_word(), i != 11);
    drain();
  endtask

  task automatic test_random();
    int burst;
    for (int phase = 0; phase < 6; phase++) begin
      load_config(phase == 0 ? idm_pkg::CfgReset : rand_config());
      for (int i = 0; i < 235; i += burst) begin
        burst = $urandom_range(1, 30);
        for (int j = 0; j < burst; j++) send_word(rand_word(), 1);
        idle_gap();
      end
      drain();
    end
  endtask

  initial begin
    cur_cfg = idm_pkg::CfgReset;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_config_extremes();
    test_random();
    $display("Checked %0d of %0d vehicle words in both modes, at extreme and random",
             words_checked, words_sent);
    $display("register settings, with %0d saturating results.", sat_seen);
    if (errors == 0 && speed_queue.size() == 0) begin
      $display("PASS idm_car_following_speed_update");
    end else begin
      $display("FAIL idm_car_following_speed_update");
    end
    $finish;
  end

endmodule
